// ===== rtl/core/csem_pkg.sv =====
// ----------------------------------------------------------------------------
// csem_pkg
// Types and constants of the counting semaphore with timed waits.
// ----------------------------------------------------------------------------
package csem_pkg;

  localparam int unsigned QueueDepth  = 16;
  localparam int unsigned ThreadBits  = 8;
  localparam int unsigned TimeoutBits = 16;

  typedef enum logic [1:0] {
    ModeWait   = 2'd0,
    ModeSignal = 2'd1,
    ModeTick   = 2'd2,
    ModeNone   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    EvGranted  = 3'd0,
    EvBlocked  = 3'd1,
    EvWokenSig = 3'd2,
    EvWokenTmo = 3'd3,
    EvSigDone  = 3'd4,
    EvRejected = 3'd5,
    EvTickDone = 3'd6
  } event_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [7:0]         thread_id;
    logic [15:0]        max_wait;
    logic signed [15:0] signal_count;
  } req_t;

  typedef struct packed {
    logic [2:0]         event_res;
    logic [7:0]         thread_id_out;
    logic signed [15:0] return_value;
    logic signed [15:0] count_now;
    logic               last;
  } rsp_t;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StScan,
    StEmit,
    StDone
  } state_e;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) begin
      return 16'sh7fff;
    end else if (v < -18'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

endpackage

// ===== rtl/core/counting_semaphore_timed_waits.sv =====
// ----------------------------------------------------------------------------
// counting_semaphore_timed_waits
// Counting semaphore with an ordered, timed waiter list.
// ----------------------------------------------------------------------------
// Usage: request beats (in_valid_i/in_stall_o, in_data_i) carry waits,
// signals and timer ticks. Response beats (out_valid_o/out_stall_i,
// out_data_o) give one or more events per request; the final one has
// last set. cfg_we_i with cfg_data_i reloads the count and empties the list.
// The waiters sit in a circular memory, each entry read and written back
// in turn, through the scan and emit states. The event beat of a wait or
// a negative signal is staged in the read state; the first one of any
// other signal or a tick in the scan state, after the registered read.
// A signal passes scan and emit once per woken waiter, a tick once per
// waiter; the memory sweep sets the time per request, and no request is
// taken while busy or holding an event. A timed-out waiter is closed up
// by copying later entries down during the same sweep. After reset the
// count is 0 and the list is empty. While the receiver stalls, the held
// event stays, the sweep waits before staging another and requests stall.
// ----------------------------------------------------------------------------
module counting_semaphore_timed_waits #(
  parameter int unsigned QUEUE_DEPTH  = csem_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [14:0]     cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  csem_pkg::req_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output csem_pkg::rsp_t  out_data_o
);

  localparam int unsigned THREAD_BITS  = csem_pkg::ThreadBits;
  localparam int unsigned TIMEOUT_BITS = csem_pkg::TimeoutBits;
  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned MW = THREAD_BITS + TIMEOUT_BITS;
  localparam logic [NW-1:0] Full = NW'(QUEUE_DEPTH);

  csem_pkg::state_e state_q, state_d;
  csem_pkg::req_t   req_q;
  csem_pkg::rsp_t   rsp_q, rsp_d;
  logic             ov_q, ov_d;
  logic signed [15:0] cnt_q, cnt_d;
  logic [AW-1:0]    head_q, head_d;
  logic [NW-1:0]    tot_q, tot_d;
  logic [NW-1:0]    idx_q, idx_d;   // read position within list
  logic [NW-1:0]    wr_q, wr_d;     // write-back position (compaction)
  logic [15:0]      rel_q, rel_d;
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [MW-1:0]    wdata, rdata;
  logic [THREAD_BITS-1:0]  r_id;
  logic [TIMEOUT_BITS-1:0] r_tmo;
  logic signed [15:0] n;
  logic             take;
  logic             room;

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] b, input logic [NW-1:0] o);
    logic [NW:0] s;
    s = {1'b0, NW'(b)} + {1'b0, o};
    if (s >= (NW+1)'(QUEUE_DEPTH)) begin
      s = s - (NW+1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign r_id  = rdata[MW-1:TIMEOUT_BITS];
  assign r_tmo = rdata[TIMEOUT_BITS-1:0];
  assign n     = req_q.signal_count;
  assign take  = in_valid_i && !in_stall_o;
  assign room  = !ov_q || !out_stall_i;
  assign in_stall_o  = (state_q != csem_pkg::StIdle) || ov_q;
  assign out_valid_o = ov_q;
  assign out_data_o  = rsp_q;

  csem_queue_mem #(.Depth(QUEUE_DEPTH), .Width(MW), .AddrW(AW)) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      csem_pkg::StIdle: begin
        if (take) begin
          state_d = csem_pkg::StRead;
        end
      end
      csem_pkg::StRead: begin
        case (req_q.mode)
          csem_pkg::ModeWait: state_d = csem_pkg::StIdle;
          csem_pkg::ModeSignal: begin
            if (n < 0) begin
              state_d = csem_pkg::StIdle;
            end else begin
              state_d = csem_pkg::StScan;
            end
          end
          csem_pkg::ModeTick: state_d = csem_pkg::StScan;
          default: state_d = csem_pkg::StIdle;
        endcase
      end
      csem_pkg::StScan: begin
        if (req_q.mode == csem_pkg::ModeSignal) begin
          if (rel_q != 16'd0 && tot_q != '0) begin
            if (room) begin
              state_d = csem_pkg::StEmit;
            end
          end else if (room) begin
            state_d = csem_pkg::StIdle;
          end
        end else if (idx_q < tot_q) begin
          if (r_tmo != TIMEOUT_BITS'(1) || room) begin
            state_d = csem_pkg::StEmit;
          end
        end else if (room) begin
          state_d = csem_pkg::StIdle;
        end
      end
      csem_pkg::StEmit: state_d = csem_pkg::StScan;
      default: state_d = csem_pkg::StIdle;
    endcase
  end

  always_comb begin
    logic signed [17:0] sum;
    logic         more;
    cnt_d  = cnt_q;
    head_d = head_q;
    tot_d  = tot_q;
    idx_d  = idx_q;
    wr_d   = wr_q;
    rel_d  = rel_q;
    rsp_d  = rsp_q;
    ov_d   = ov_q && out_stall_i;
    we     = 1'b0;
    waddr  = wrap(head_q, wr_q);
    wdata  = rdata;
    raddr  = wrap(head_q, idx_q);
    sum    = '0;
    more   = 1'b0;
    case (state_q)
      csem_pkg::StRead: begin
        idx_d = '0;
        wr_d  = '0;
        rel_d = '0;
        raddr = head_q;
        case (req_q.mode)
          csem_pkg::ModeWait: begin
            rsp_d.thread_id_out = 8'(req_q.thread_id[THREAD_BITS-1:0]);
            rsp_d.last = 1'b1;
            ov_d = 1'b1;
            if (cnt_q > 16'sd0) begin
              cnt_d = cnt_q - 16'sd1;
              rsp_d.event_res = csem_pkg::EvGranted;
              rsp_d.return_value = 16'sd1;
            end else if (tot_q < Full) begin
              cnt_d = csem_pkg::sat16(18'(cnt_q) - 18'sd1);
              we    = 1'b1;
              waddr = wrap(head_q, tot_q);
              wdata = {req_q.thread_id[THREAD_BITS-1:0],
                       req_q.max_wait[TIMEOUT_BITS-1:0]};
              tot_d = tot_q + NW'(1);
              rsp_d.event_res = csem_pkg::EvBlocked;
              rsp_d.return_value = '0;
            end else begin
              rsp_d.event_res = csem_pkg::EvRejected;
              rsp_d.return_value = '0;
            end
            rsp_d.count_now = cnt_d;
          end
          csem_pkg::ModeSignal: begin
            if (n < 0) begin
              rsp_d = '{csem_pkg::EvSigDone, 8'd0, n, cnt_q, 1'b1};
              ov_d = 1'b1;
            end else if (n == 0) begin
              cnt_d = csem_pkg::sat16(18'(cnt_q) + 18'sd1);
              rel_d = (cnt_d <= 16'sd0) ? 16'd1 : 16'd0;
            end else begin
              cnt_d = csem_pkg::sat16(18'(cnt_q) + 18'(n));
              rel_d = n;
            end
          end
          default: ;
        endcase
      end
      csem_pkg::StScan: begin
        // rdata holds entry idx_q; decide and stage output, wait if stalled
        if (req_q.mode == csem_pkg::ModeSignal) begin
          if (rel_q != 16'd0 && tot_q != '0) begin
            if (room) begin
              rsp_d = '{csem_pkg::EvWokenSig, 8'(r_id), 16'sd1, cnt_q, 1'b0};
              ov_d  = 1'b1;
              head_d = wrap(head_q, NW'(1));
              tot_d = tot_q - NW'(1);
              rel_d = rel_q - 16'd1;
              wr_d  = wr_q + NW'(1);
            end
          end else if (room) begin
            rsp_d = '{csem_pkg::EvSigDone, 8'd0, 16'(wr_q), cnt_q, 1'b1};
            if (n == 16'sd0) begin
              rsp_d.return_value = '0;
            end
            ov_d = 1'b1;
          end
        end else begin
          if (idx_q < tot_q) begin
            if (r_tmo == TIMEOUT_BITS'(1)) begin
              if (room) begin
                sum   = 18'(cnt_q) + 18'sd1;
                cnt_d = csem_pkg::sat16(sum);
                rsp_d = '{csem_pkg::EvWokenTmo, 8'(r_id), 16'sd0, cnt_d, 1'b0};
                ov_d  = 1'b1;
                idx_d = idx_q + NW'(1);
              end
            end else begin
              we    = 1'b1;
              wdata = {r_id, (r_tmo == '0) ? r_tmo : r_tmo - TIMEOUT_BITS'(1)};
              idx_d = idx_q + NW'(1);
              wr_d  = wr_q + NW'(1);
            end
          end else if (room) begin
            tot_d = wr_q;
            rsp_d = '{csem_pkg::EvTickDone, 8'd0, 16'sd0, cnt_q, 1'b1};
            ov_d = 1'b1;
          end
        end
      end
      csem_pkg::StEmit: begin
        // re-read the next entry
        more = 1'b1;
      end
      default: ;
    endcase
    if (more) begin
      raddr = (req_q.mode == csem_pkg::ModeSignal) ? head_q : wrap(head_q, idx_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csem_pkg::StIdle;
      ov_q    <= 1'b0;
      cnt_q   <= '0;
      head_q  <= '0;
      tot_q   <= '0;
    end else if (cfg_we_i) begin
      state_q <= csem_pkg::StIdle;
      ov_q    <= 1'b0;
      cnt_q   <= 16'(cfg_data_i);
      head_q  <= '0;
      tot_q   <= '0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      cnt_q   <= cnt_d;
      head_q  <= head_d;
      tot_q   <= tot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      req_q <= in_data_i;
    end
    rsp_q <= rsp_d;
    idx_q <= idx_d;
    wr_q  <= wr_d;
    rel_q <= rel_d;
  end

  a_tot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tot_q <= Full) else $error("waiter total above depth");
  a_idle_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && !cfg_we_i |=> state_q == csem_pkg::StRead) else $error("accept did not start");
  a_wait_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == csem_pkg::StRead && req_q.mode == csem_pkg::ModeWait && !cfg_we_i)
    |=> ov_q && rsp_q.last) else $error("wait gave no final beat");

endmodule

// ===== rtl/core/csem_queue_mem.sv =====
// ----------------------------------------------------------------------------
// csem_queue_mem
// Waiter memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module csem_queue_mem #(
  parameter int unsigned Depth = csem_pkg::QueueDepth,
  parameter int unsigned Width = 24,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for the counting semaphore with timed waits. Directed
// tests cover grants, blocking, a full waiter list, every kind of signal,
// timeouts and count saturation. Random tests then mix well-formed
// wait/signal/tick traffic with noise. A predictor queues the expected
// events for each accepted request beat, and a checker compares every
// response beat against them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned Depth = csem_pkg::QueueDepth;
  localparam int unsigned IdleLimit = 2000;

  logic           clk_i;
  logic           rst_ni;
  logic           cfg_we_i;
  logic [14:0]    cfg_data_i;
  logic           in_valid_i;
  logic           in_stall_o;
  csem_pkg::req_t in_data_i;
  logic           out_valid_o;
  logic           out_stall_i;
  csem_pkg::rsp_t out_data_o;

  counting_semaphore_timed_waits i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // semaphore state mirror
  int             sem_count;
  logic [7:0]     wl_id[$];
  logic [15:0]    wl_tmo[$];
  csem_pkg::rsp_t event_q[$];

  int  errors;
  int  idle_cycles;
  bit  src_jitter;
  bit  sink_jitter;
  bit  hold_sink;

  function automatic int clamp_count(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic void push_event(csem_pkg::event_e ev, logic [7:0] tid, int ret,
                                     logic lst);
    csem_pkg::rsp_t r;
    r.event_res     = ev;
    r.thread_id_out = tid;
    r.return_value  = ret[15:0];
    r.count_now     = sem_count[15:0];
    r.last          = lst;
    event_q.push_back(r);
  endfunction

  function automatic void predict_events(csem_pkg::req_t rq);
    int n;
    int woken;
    int i;
    n = int'(rq.signal_count);
    woken = 0;
    case (csem_pkg::mode_e'(rq.mode))
      csem_pkg::ModeWait: begin
        if (sem_count - 1 >= 0) begin
          sem_count--;
          push_event(csem_pkg::EvGranted, rq.thread_id, 1, 1'b1);
        end else if (wl_id.size() < Depth) begin
          sem_count = clamp_count(sem_count - 1);
          wl_id.push_back(rq.thread_id);
          wl_tmo.push_back(rq.max_wait);
          push_event(csem_pkg::EvBlocked, rq.thread_id, 0, 1'b1);
        end else begin
          push_event(csem_pkg::EvRejected, rq.thread_id, 0, 1'b1);
        end
      end
      csem_pkg::ModeSignal: begin
        if (n < 0) begin
          push_event(csem_pkg::EvSigDone, 8'd0, n, 1'b1);
        end else begin
          if (n == 0) begin
            sem_count = clamp_count(sem_count + 1);
            if (sem_count <= 0 && wl_id.size() > 0) begin
              push_event(csem_pkg::EvWokenSig, wl_id.pop_front(), 1, 1'b0);
              void'(wl_tmo.pop_front());
            end
          end else begin
            sem_count = clamp_count(sem_count + n);
            while (woken < n && wl_id.size() > 0) begin
              push_event(csem_pkg::EvWokenSig, wl_id.pop_front(), 1, 1'b0);
              void'(wl_tmo.pop_front());
              woken++;
            end
          end
          push_event(csem_pkg::EvSigDone, 8'd0, woken, 1'b1);
        end
      end
      csem_pkg::ModeTick: begin
        i = 0;
        while (i < wl_id.size()) begin
          if (wl_tmo[i] != 0) begin
            wl_tmo[i]--;
            if (wl_tmo[i] == 0) begin
              sem_count = clamp_count(sem_count + 1);
              push_event(csem_pkg::EvWokenTmo, wl_id[i], 0, 1'b0);
              wl_id.delete(i);
              wl_tmo.delete(i);
              continue;
            end
          end
          i++;
        end
        push_event(csem_pkg::EvTickDone, 8'd0, 0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  // request driver
  task automatic send_beat(csem_pkg::req_t rq);
    int gap;
    if (src_jitter && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= rq;
    do @(posedge clk_i); while (in_stall_o);
    predict_events(rq);
  endtask

  task automatic send_op(csem_pkg::mode_e m, int tid, int tmo, int n);
    csem_pkg::req_t rq;
    rq.mode         = m;
    rq.thread_id    = tid[7:0];
    rq.max_wait     = tmo[15:0];
    rq.signal_count = n[15:0];
    send_beat(rq);
  endtask

  task automatic drain_events();
    in_valid_i <= 1'b0;
    while (event_q.size() != 0) @(posedge clk_i);
    repeat (2 * Depth + 8) @(posedge clk_i);
  endtask

  task automatic load_count(int v);
    drain_events();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v[14:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sem_count = v;
    wl_id.delete();
    wl_tmo.delete();
  endtask

  // response checker
  always @(posedge clk_i) begin
    csem_pkg::rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (event_q.size() == 0) begin
        $display("%0t unexpected beat: expected none, actual %h", $time, out_data_o);
        errors++;
      end else begin
        want = event_q.pop_front();
        if (out_data_o.event_res !== want.event_res ||
            out_data_o.thread_id_out !== want.thread_id_out ||
            out_data_o.return_value !== want.return_value ||
            out_data_o.count_now !== want.count_now ||
            out_data_o.last !== want.last) begin
          $display({"%0t mismatch: expected ev=%0d tid=%0d ret=%0d cnt=%0d last=%0b,",
                    " actual ev=%0d tid=%0d ret=%0d cnt=%0d last=%0b"},
                   $time, want.event_res, want.thread_id_out, want.return_value,
                   want.count_now, want.last, out_data_o.event_res,
                   out_data_o.thread_id_out, out_data_o.return_value,
                   out_data_o.count_now, out_data_o.last);
          errors++;
        end
      end
    end
  end

  // receiver stall
  initial begin
    int burst;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_sink) begin
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_sink = 1'b0;
      end else if (sink_jitter && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 19);
        out_stall_i <= 1'b1;
        repeat (burst) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i ||
        !rst_ni) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("counting_semaphore_timed_waits regression: fail");
        $finish;
      end
    end
  end

  task automatic test_grant_and_block();
    load_count(2);
    send_op(csem_pkg::ModeWait, 8'hff, 0, 0);
    send_op(csem_pkg::ModeWait, 0, 16'hffff, -1);
    send_op(csem_pkg::ModeWait, 8'h55, 0, 0);
    send_op(csem_pkg::ModeWait, 8'haa, 3, 0);
    send_op(csem_pkg::ModeSignal, 0, 0, 0);
    send_op(csem_pkg::ModeSignal, 0, 0, 0);
    send_op(csem_pkg::ModeSignal, 0, 0, 0);
  endtask

  task automatic test_full_list();
    load_count(0);
    for (int i = 0; i < Depth; i++) send_op(csem_pkg::ModeWait, i, i % 4, 0);
    send_op(csem_pkg::ModeWait, 8'h80, 7, 0);
    send_op(csem_pkg::ModeSignal, 0, 0, -32768);
    send_op(csem_pkg::ModeSignal, 0, 0, -5);
    send_op(csem_pkg::ModeTick, 8'hff, 16'hffff, 32767);
    send_op(csem_pkg::ModeSignal, 0, 0, 3);
    send_op(csem_pkg::ModeTick, 0, 0, 0);
    send_op(csem_pkg::ModeTick, 0, 0, 0);
    send_op(csem_pkg::ModeSignal, 0, 0, 32767);
    send_op(csem_pkg::ModeSignal, 0, 0, 32767);
    send_op(csem_pkg::ModeNone, 8'hff, 16'hffff, -1);
  endtask

  task automatic test_saturation();
    load_count(32767);
    send_op(csem_pkg::ModeSignal, 0, 0, 0);
    send_op(csem_pkg::ModeSignal, 0, 0, 100);
    send_op(csem_pkg::ModeWait, 1, 0, 0);
    send_op(csem_pkg::ModeTick, 0, 0, 0);
  endtask

  task automatic test_random_mix(int items, int init);
    int r;
    load_count(init);
    for (int k = 0; k < items; k++) begin
      r = $urandom_range(0, 99);
      if (r < 45)
        send_op(csem_pkg::ModeWait, $urandom_range(0, 255),
                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) :
                                              $urandom_range(0, 5), 0);
      else if (r < 70)
        send_op(csem_pkg::ModeSignal, $urandom_range(0, 255), $urandom_range(0, 65535),
                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) :
                                              $urandom_range(0, 4));
      else if (r < 95)
        send_op(csem_pkg::ModeTick, $urandom_range(0, 255), $urandom_range(0, 65535), 0);
      else
        send_op(csem_pkg::mode_e'($urandom_range(0, 3)), $urandom_range(0, 255),
                $urandom_range(0, 65535), $urandom_range(0, 65535));
    end
  endtask

  task automatic test_backpressure();
    load_count(0);
    hold_sink = 1'b1;
    for (int i = 0; i < 20; i++) send_op(csem_pkg::ModeWait, i, 2, 0);
    send_op(csem_pkg::ModeTick, 0, 0, 0);
    send_op(csem_pkg::ModeTick, 0, 0, 0);
  endtask

  initial begin
    errors      = 0;
    idle_cycles = 0;
    src_jitter  = 1'b0;
    sink_jitter = 1'b0;
    hold_sink   = 1'b0;
    sem_count   = 0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_grant_and_block();
    test_full_list();
    test_saturation();
    src_jitter  = 1'b1;
    sink_jitter = 1'b1;
    test_random_mix(70, 0);
    test_random_mix(50, 3);
    test_backpressure();
    test_random_mix(50, 1);
    src_jitter  = 1'b0;
    sink_jitter = 1'b0;
    test_random_mix(40, 0);
    drain_events();
    if (errors == 0 && event_q.size() == 0) begin
      $display("counting_semaphore_timed_waits regression: pass");
    end else begin
      $display("counting_semaphore_timed_waits regression: fail");
    end
    $finish;
  end

endmodule
